// ===== hw/rtl/ssf_pkg.sv =====
// Shared types, codes and constants of the servo source failover block.
package ssf_pkg;

  localparam int SERVO_COUNT_DEF   = 8;
  localparam int CHANNEL_COUNT_DEF = 8;
  localparam int CMD_DEPTH         = 2;
  localparam int RES_DEPTH         = 8;

  localparam int SERVO_IDX_W = 3;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [1:0] {
    OP_HOST_SET  = 2'd0,
    OP_RX_UPDATE = 2'd1,
    OP_EVALUATE  = 2'd2,
    OP_TICK      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_HOST     = 2'd0,
    MODE_RX       = 2'd1,
    MODE_FAILSAFE = 2'd2
  } mode_t;

  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT         = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FORCE_CHANNEL   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FORCE_ABOVE     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FORCE_THRESHOLD = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RX_MAP          = 3'd4;

  localparam logic [15:0] TIMEOUT_RST = 16'd2000;
  localparam logic [31:0] RX_MAP_RST  = 32'h7654_3210;

  typedef struct packed {
    op_t         op;
    logic [3:0]  index;
    logic [11:0] pulse_us;
  } item_t;

  typedef struct packed {
    logic [SERVO_IDX_W-1:0] servo_index;
    mode_t                  mode;
    logic                   drive;
    logic [11:0]            drive_pulse;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [3:0]  force_channel;
    logic        force_above;
    logic [11:0] force_threshold;
    logic [31:0] rx_map;
  } cfg_t;

endpackage

// ===== hw/rtl/ssf_fifo.sv =====
// Small flip-flop queue used between the front, the back and the result port.
module ssf_fifo #(
  parameter int W     = 18,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW:0] DEPTH_CNT = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   cnt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt == DEPTH_CNT);
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == LAST_PTR) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == LAST_PTR) ? '0 : rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/ssf_front.sv =====
// Front end: accepts transactions, drops out-of-range ones and queues the rest.
module ssf_front #(
  parameter int SERVO_COUNT   = ssf_pkg::SERVO_COUNT_DEF,
  parameter int CHANNEL_COUNT = ssf_pkg::CHANNEL_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ssf_pkg::item_t item,
  output logic           full,
  output logic           cmd_valid,
  output ssf_pkg::item_t cmd,
  input  logic           cmd_pop
);

  localparam logic [4:0] SV_LIM = 5'(SERVO_COUNT);
  localparam logic [4:0] CH_LIM = 5'(CHANNEL_COUNT);

  logic                          keep;
  logic                          empty;
  logic [$bits(ssf_pkg::item_t)-1:0] q_rdata;

  always_comb begin
    unique case (item.op)
      ssf_pkg::OP_HOST_SET,
      ssf_pkg::OP_EVALUATE:  keep = ({1'b0, item.index} < SV_LIM);
      ssf_pkg::OP_RX_UPDATE: keep = ({1'b0, item.index} < CH_LIM);
      ssf_pkg::OP_TICK:      keep = 1'b1;
      default:               keep = 1'b0;
    endcase
  end

  ssf_fifo #(
    .W     ($bits(ssf_pkg::item_t)),
    .DEPTH (ssf_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && keep),
    .wdata (item),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (q_rdata),
    .empty (empty)
  );

  assign cmd       = ssf_pkg::item_t'(q_rdata);
  assign cmd_valid = !empty;

endmodule

// ===== hw/rtl/ssf_back.sv =====
// Back end: holds servo and channel state, evaluates servos and emits results.
module ssf_back #(
  parameter int SERVO_COUNT   = ssf_pkg::SERVO_COUNT_DEF,
  parameter int CHANNEL_COUNT = ssf_pkg::CHANNEL_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  ssf_pkg::cfg_t    cfg,
  input  logic             cmd_valid,
  input  ssf_pkg::item_t   cmd,
  output logic             cmd_pop,
  input  logic             res_full,
  output logic             res_push,
  output ssf_pkg::result_t res
);

  localparam int SV_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
  localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [4:0] CH_LIM = 5'(CHANNEL_COUNT);
  localparam logic [SV_W-1:0] SV_LAST = SV_W'(SERVO_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_F,
    ST_RD_R,
    ST_EVAL,
    ST_SCAN
  } state_t;

  state_t          state;
  logic [31:0]     now_ms;
  logic [31:0]     host_stamp [SERVO_COUNT];
  ssf_pkg::mode_t  servo_mode [SERVO_COUNT];
  logic [11:0]     chan_mem [CHANNEL_COUNT];
  logic            chan_vld [CHANNEL_COUNT];
  logic [11:0]     rd_data;
  logic            rd_vld;
  logic [11:0]     fval;
  ssf_pkg::op_t    op;
  logic [3:0]      ch;
  logic [11:0]     pulse;
  logic [SV_W-1:0] s;

  logic [CH_W-1:0] rd_addr;
  logic [3:0]      fc;
  logic            fc_ok;
  logic [3:0]      rc;
  logic            rc_ok;
  logic [11:0]     rval;
  logic            rx_ok;
  logic            f_valid;
  logic            f_active;
  logic            pred;
  logic            force_on;
  logic            no_force;
  logic [31:0]     age;
  logic            expired;
  logic            by_timeout;
  logic            stay_host;
  ssf_pkg::mode_t  new_mode;
  logic [11:0]     ev_pulse;
  logic [SERVO_COUNT-1:0] match;
  logic            later;

  assign fc    = cfg.force_channel;
  assign fc_ok = ({1'b0, fc} < CH_LIM);
  assign rc    = cfg.rx_map[4*s +: 4];
  assign rc_ok = ({1'b0, rc} < CH_LIM);

  // Keep the mapped channel address while the decision waits, so the read data holds.
  always_comb begin
    rd_addr = '0;
    if (state == ST_RD_F && fc_ok) begin
      rd_addr = fc[CH_W-1:0];
    end else if ((state == ST_RD_R || state == ST_EVAL) && rc_ok) begin
      rd_addr = rc[CH_W-1:0];
    end
  end

  // Fallback decision for servo s, from the captured force value and mapped value.
  always_comb begin
    rval       = (rd_vld && rc_ok) ? rd_data : 12'd0;
    rx_ok      = rc_ok && (rval != 12'd0);
    f_valid    = fc_ok && (fval != 12'd0);
    f_active   = fc_ok && (cfg.force_threshold != 12'd0);
    pred       = cfg.force_above ? (fval > cfg.force_threshold)
                                 : (fval < cfg.force_threshold);
    force_on   = f_active && f_valid && pred;
    no_force   = !f_active || (f_valid && !pred);
    age        = now_ms - host_stamp[s];
    expired    = age > {16'd0, cfg.timeout_ms};
    by_timeout = (cfg.timeout_ms != 16'd0) && expired;
    stay_host  = !expired && no_force;
    if (stay_host) begin
      new_mode = ssf_pkg::MODE_HOST;
      ev_pulse = 12'd0;
    end else if ((force_on || by_timeout) && rx_ok) begin
      new_mode = ssf_pkg::MODE_RX;
      ev_pulse = rval;
    end else begin
      new_mode = ssf_pkg::MODE_FAILSAFE;
      ev_pulse = 12'd0;
    end
  end

  always_comb begin
    later = 1'b0;
    for (int i = 0; i < SERVO_COUNT; i++) begin
      match[i] = (servo_mode[i] == ssf_pkg::MODE_RX) && (cfg.rx_map[4*i +: 4] == ch);
      if (i > int'(s) && match[i]) begin
        later = 1'b1;
      end
    end
  end

  assign cmd_pop = (state == ST_IDLE) && cmd_valid;

  always_comb begin
    res_push = 1'b0;
    res      = '0;
    unique case (state)
      ST_EVAL: begin
        res_push          = !res_full;
        res.servo_index   = ssf_pkg::SERVO_IDX_W'(s);
        res.mode          = new_mode;
        res.drive         = (op == ssf_pkg::OP_HOST_SET) || !stay_host;
        res.drive_pulse   = (op == ssf_pkg::OP_HOST_SET && stay_host) ? pulse : ev_pulse;
        res.last          = 1'b1;
      end
      ST_SCAN: begin
        res_push          = match[s] && !res_full;
        res.servo_index   = ssf_pkg::SERVO_IDX_W'(s);
        res.mode          = ssf_pkg::MODE_RX;
        res.drive         = 1'b1;
        res.drive_pulse   = pulse;
        res.last          = !later;
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= chan_mem[rd_addr];
    if (cmd_pop && cmd.op == ssf_pkg::OP_RX_UPDATE) begin
      chan_mem[cmd.index[CH_W-1:0]] <= cmd.pulse_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      now_ms <= '0;
      rd_vld <= 1'b0;
      for (int i = 0; i < SERVO_COUNT; i++) begin
        host_stamp[i] <= '0;
        servo_mode[i] <= ssf_pkg::MODE_HOST;
      end
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        chan_vld[i] <= 1'b0;
      end
    end else begin
      rd_vld <= chan_vld[rd_addr];
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            op    <= cmd.op;
            ch    <= cmd.index;
            pulse <= cmd.pulse_us;
            unique case (cmd.op)
              ssf_pkg::OP_HOST_SET: begin
                s     <= cmd.index[SV_W-1:0];
                host_stamp[cmd.index[SV_W-1:0]] <= now_ms;
                state <= ST_RD_F;
              end
              ssf_pkg::OP_EVALUATE: begin
                s     <= cmd.index[SV_W-1:0];
                state <= ST_RD_F;
              end
              ssf_pkg::OP_RX_UPDATE: begin
                chan_vld[cmd.index[CH_W-1:0]] <= 1'b1;
                s     <= '0;
                state <= ST_SCAN;
              end
              default: begin
                now_ms <= now_ms + 32'd1;
              end
            endcase
          end
        end
        ST_RD_F: begin
          state <= ST_RD_R;
        end
        ST_RD_R: begin
          fval  <= (rd_vld && fc_ok) ? rd_data : 12'd0;
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (!res_full) begin
            servo_mode[s] <= new_mode;
            // Age the stamp so only a fresh host command returns to host mode.
            if (!stay_host) begin
              host_stamp[s] <= now_ms - {16'd0, cfg.timeout_ms};
            end
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (!match[s] || !res_full) begin
            if (s == SV_LAST) begin
              state <= ST_IDLE;
            end else begin
              s <= s + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_tick_counts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && cmd_valid && cmd.op == ssf_pkg::OP_TICK)
      |=> now_ms == $past(now_ms) + 32'd1)
    else $error("millisecond counter did not advance on tick");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.last) |=> !res_push)
    else $error("result followed the last one of the transaction");

  a_host_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL && res_push && res.mode == ssf_pkg::MODE_HOST)
      |-> (!res.drive || op == ssf_pkg::OP_HOST_SET))
    else $error("evaluate drove a servo in host mode");
`endif

endmodule

// ===== hw/rtl/servo_source_failover.sv =====
// Top level of the servo source failover block: configuration, front, back, result queue.
//
// Input side is a queue: present an item and raise push; it is taken at a clock
// edge where full is low. Ops: host set, receiver update, evaluate, tick.
// Result side is a queue: while empty is low the oldest result is on result;
// raise pop to take it. Each result carries last on the final one of a transaction.
// Configuration: cfg_we with cfg_addr and cfg_data writes one register in a
// cycle; write only while no transaction is in flight. Unknown indexes are ignored.
// Timing: items enter a two-entry command queue. Host set and evaluate pass the back
// end states read force, read mapped and evaluate (two reads through the single read
// port of the channel store, then the decision). A receiver update scans one servo
// per cycle while no match waits on a full result queue; a tick only advances time.
// Items with an out-of-range servo or channel are dropped without a result.
// A stalled receiver fills the eight-entry result queue; the back end then
// holds, the command queue fills and full rises. Synchronous reset returns
// registers to defaults, all servos to host mode, stamps and time to zero and
// every receiver channel to invalid.
module servo_source_failover #(
  parameter int SERVO_COUNT   = ssf_pkg::SERVO_COUNT_DEF,
  parameter int CHANNEL_COUNT = ssf_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  ssf_pkg::item_t                 item,
  output logic                           full,
  output logic                           empty,
  input  logic                           pop,
  output ssf_pkg::result_t               result,
  input  logic                           cfg_we,
  input  logic [ssf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ssf_pkg::CFG_DATA_W-1:0] cfg_data
);

  ssf_pkg::cfg_t    cfg;
  logic             cmd_valid;
  ssf_pkg::item_t   cmd;
  logic             cmd_pop;
  logic             res_full;
  logic             res_push;
  ssf_pkg::result_t res;
  logic [$bits(ssf_pkg::result_t)-1:0] res_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ms      <= ssf_pkg::TIMEOUT_RST;
      cfg.force_channel   <= '0;
      cfg.force_above     <= 1'b0;
      cfg.force_threshold <= '0;
      cfg.rx_map          <= ssf_pkg::RX_MAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ssf_pkg::REG_TIMEOUT:         cfg.timeout_ms      <= cfg_data[15:0];
        ssf_pkg::REG_FORCE_CHANNEL:   cfg.force_channel   <= cfg_data[3:0];
        ssf_pkg::REG_FORCE_ABOVE:     cfg.force_above     <= cfg_data[0];
        ssf_pkg::REG_FORCE_THRESHOLD: cfg.force_threshold <= cfg_data[11:0];
        ssf_pkg::REG_RX_MAP:          cfg.rx_map          <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  ssf_front #(
    .SERVO_COUNT   (SERVO_COUNT),
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  ssf_back #(
    .SERVO_COUNT   (SERVO_COUNT),
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  ssf_fifo #(
    .W     ($bits(ssf_pkg::result_t)),
    .DEPTH (ssf_pkg::RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign result = ssf_pkg::result_t'(res_rdata);

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the servo source failover block: directed table, then random phases.
module testbench;
  import ssf_pkg::*;

  localparam int NSERVO        = SERVO_COUNT_DEF;
  localparam int NCHAN         = CHANNEL_COUNT_DEF;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 2 * (NSERVO + 1) + 12;
  localparam int PHASE_ITEMS   = 48;
  localparam int PHASE_COUNT   = 6;
  localparam int MAX_SHOWN     = 10;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = REG_RX_MAP + 3'd1;

  typedef struct {
    bit      set_row;
    cfg_t    cfg;
    item_t   it;
    bit      typed;
    result_t want;
  } plan_row_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  push     = 1'b0;
  item_t                 item     = '0;
  logic                  full;
  logic                  empty;
  logic                  pop      = 1'b0;
  result_t               result;
  logic                  cfg_we   = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predicted block state and settings
  cfg_t        cfg_now;
  logic [31:0] now_ms;
  logic [31:0] stamp      [NSERVO];
  mode_t       servo_mode [NSERVO];
  logic [11:0] chan_pulse [NCHAN];

  result_t   fresh[$];
  result_t   due_results[$];
  plan_row_t plan[$];
  result_t   want_r;

  bit hold_req = 1'b0;
  bit calm     = 1'b0;
  int bad_results   = 0;
  int results_seen  = 0;
  int items_in      = 0;
  int silent_items  = 0;
  int full_stalls   = 0;
  int settings_used = 0;
  int mode_count [3] = '{0, 0, 0};

  servo_source_failover u_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial forever #2 clk = ~clk;

  function automatic result_t make_result(int s, mode_t m, logic d, logic [11:0] p, logic l);
    result_t r;
    r.servo_index = SERVO_IDX_W'(s);
    r.mode        = m;
    r.drive       = d;
    r.drive_pulse = p;
    r.last        = l;
    return r;
  endfunction

  function automatic cfg_t make_cfg(logic [15:0] t, logic [3:0] fc, logic fa, logic [11:0] th,
                                    logic [31:0] map);
    cfg_t c;
    c.timeout_ms      = t;
    c.force_channel   = fc;
    c.force_above     = fa;
    c.force_threshold = th;
    c.rx_map          = map;
    return c;
  endfunction

  // Decide the source of servo s; returns the fallback pulse, 0 in host or failsafe mode.
  function automatic logic [11:0] pick_source(int s);
    logic [3:0]  fc;
    logic [3:0]  rc;
    logic [11:0] fval;
    logic [11:0] rval;
    bit fc_ok, f_valid, f_active, over, forced, unforced, expired, by_timeout, rx_ok;
    fc       = cfg_now.force_channel;
    fc_ok    = fc < NCHAN;
    fval     = fc_ok ? chan_pulse[fc] : 12'd0;
    f_valid  = fc_ok && fval != 12'd0;
    f_active = fc_ok && cfg_now.force_threshold != 12'd0;
    over     = (!cfg_now.force_above && fval < cfg_now.force_threshold) ||
               (cfg_now.force_above && fval > cfg_now.force_threshold);
    forced   = f_active && f_valid && over;
    unforced = !f_active || (f_valid && !over);
    // modulo-2^32 age of the host command
    expired    = (now_ms - stamp[s]) > {16'd0, cfg_now.timeout_ms};
    by_timeout = cfg_now.timeout_ms != 16'd0 && expired;
    rc    = cfg_now.rx_map[4*s +: 4];
    rx_ok = rc < NCHAN && chan_pulse[rc] != 12'd0;
    rval  = rx_ok ? chan_pulse[rc] : 12'd0;
    if (!expired && unforced) begin
      servo_mode[s] = MODE_HOST;
      return 12'd0;
    end
    // back-date the stamp so only a fresh host command returns to host mode
    stamp[s] = now_ms - {16'd0, cfg_now.timeout_ms};
    if ((forced || by_timeout) && rx_ok) begin
      servo_mode[s] = MODE_RX;
      return rval;
    end
    servo_mode[s] = MODE_FAILSAFE;
    return 12'd0;
  endfunction

  // Advance the predicted state by one transaction; its results land in fresh.
  function automatic void model_item(item_t it);
    logic [11:0] p;
    fresh.delete();
    case (it.op)
      OP_HOST_SET: if (it.index < NSERVO) begin
        stamp[it.index] = now_ms;
        p = pick_source(it.index);
        if (servo_mode[it.index] == MODE_HOST) p = it.pulse_us;
        fresh.push_back(make_result(it.index, servo_mode[it.index], 1'b1, p, 1'b1));
      end
      OP_RX_UPDATE: if (it.index < NCHAN) begin
        chan_pulse[it.index] = it.pulse_us;
        for (int s = 0; s < NSERVO; s++)
          if (servo_mode[s] == MODE_RX && cfg_now.rx_map[4*s +: 4] == it.index)
            fresh.push_back(make_result(s, MODE_RX, 1'b1, it.pulse_us, 1'b0));
        if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
      end
      OP_EVALUATE: if (it.index < NSERVO) begin
        p = pick_source(it.index);
        fresh.push_back(make_result(it.index, servo_mode[it.index],
                                    servo_mode[it.index] != MODE_HOST, p, 1'b1));
      end
      OP_TICK: now_ms = now_ms + 32'd1;
      default: ;
    endcase
  endfunction

  function automatic plan_row_t row_item(op_t op, int idx, int p);
    plan_row_t r;
    r.set_row  = 1'b0;
    r.cfg      = '0;
    r.it.op    = op;
    r.it.index = 4'(idx);
    r.it.pulse_us = 12'(p);
    r.typed    = 1'b0;
    r.want     = '0;
    return r;
  endfunction

  function automatic plan_row_t row_check(op_t op, int idx, int p, result_t want);
    plan_row_t r;
    r = row_item(op, idx, p);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic plan_row_t row_settings(cfg_t c);
    plan_row_t r;
    r = row_item(OP_TICK, 0, 0);
    r.set_row = 1'b1;
    r.cfg     = c;
    return r;
  endfunction

  function automatic logic [31:0] random_map();
    logic [31:0] m;
    for (int s = 0; s < 8; s++)
      m[4*s +: 4] = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(NCHAN, 15))
                                                : 4'($urandom_range(0, NCHAN - 1));
    return m;
  endfunction

  function automatic cfg_t phase_settings(int ph);
    case (ph)
      0: return make_cfg(16'd3, 4'd15, 1'b0, 12'd0, RX_MAP_RST);
      1: return make_cfg(16'd0, 4'($urandom_range(0, NCHAN - 1)), 1'b1, 12'd3000, 32'hFFFF_FFFF);
      2: return make_cfg(16'hFFFF, 4'd0, 1'b0, 12'd1500, random_map());
      3: return make_cfg(16'($urandom_range(1, 10)), 4'($urandom), 1'($urandom),
                         12'($urandom_range(0, 3000)), random_map());
      // every servo on channel 0, so one receiver update can drive all of them
      4: return make_cfg(16'd2, 4'(NCHAN - 1), 1'b1, 12'd1, 32'h0000_0000);
      default: return make_cfg(16'($urandom_range(1, 8)), 4'($urandom_range(0, NCHAN - 1)),
                               1'($urandom), 12'd0, TIMEOUT_RST == 16'd0 ? '0 : RX_MAP_RST);
    endcase
  endfunction

  function automatic item_t random_item();
    item_t it;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) it.op = OP_HOST_SET;
    else if (roll < 55) it.op = OP_RX_UPDATE;
    else if (roll < 78) it.op = OP_EVALUATE;
    else it.op = OP_TICK;
    if (it.op == OP_TICK) it.index = 4'($urandom);
    else if ($urandom_range(0, 9) == 0) it.index = 4'($urandom_range(8, 15));
    else if (it.op == OP_RX_UPDATE) it.index = 4'($urandom_range(0, NCHAN - 1));
    else it.index = 4'($urandom_range(0, NSERVO - 1));
    roll = $urandom_range(0, 9);
    if (roll < 7) it.pulse_us = 12'($urandom_range(900, 2100));
    else if (roll == 7) it.pulse_us = 12'd0;
    else if (roll == 8) it.pulse_us = 12'hFFF;
    else it.pulse_us = 12'($urandom);
    return it;
  endfunction

  task automatic send_item(input item_t it, input bit typed, input result_t want);
    item <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    items_in++;
    model_item(it);
    if (fresh.size() == 0) silent_items++;
    if (typed) due_results.push_back(want);
    else foreach (fresh[k]) due_results.push_back(fresh[k]);
  endtask

  task automatic pause(input int n);
    push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
    cfg_we   <= 1'b1;
    cfg_addr <= a;
    cfg_data <= d;
    @(posedge clk);
  endtask

  // Drain, let silent transactions finish, then write every register and one unused index.
  task automatic apply_settings(input cfg_t c);
    push <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_TIMEOUT, {16'd0, c.timeout_ms});
    write_reg(REG_FORCE_CHANNEL, {28'd0, c.force_channel});
    write_reg(REG_FORCE_ABOVE, {31'd0, c.force_above});
    write_reg(REG_FORCE_THRESHOLD, {20'd0, c.force_threshold});
    write_reg(REG_RX_MAP, c.rx_map);
    write_reg(REG_SPARE + CFG_ADDR_W'($urandom_range(0, 2)), $urandom);
    cfg_we  <= 1'b0;
    cfg_now = c;
    settings_used++;
  endtask

  // Result side: random pop bursts, one long hold-off on request, steady at the end.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end else begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && push && full) full_stalls++;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (due_results.size() == 0) begin
        bad_results++;
        if (bad_results <= MAX_SHOWN)
          $display("unexpected result at %0t: servo %0d mode %0d drive %0b pulse %0d last %0b",
                   $time, result.servo_index, result.mode, result.drive,
                   result.drive_pulse, result.last);
      end else begin
        want_r = due_results.pop_front();
        mode_count[want_r.mode]++;
        if (result.servo_index !== want_r.servo_index || result.mode !== want_r.mode ||
            result.drive !== want_r.drive || result.drive_pulse !== want_r.drive_pulse ||
            result.last !== want_r.last) begin
          bad_results++;
          if (bad_results <= MAX_SHOWN) begin
            $display("mismatch at %0t: expected servo %0d mode %0d drive %0b pulse %0d last %0b",
                     $time, want_r.servo_index, want_r.mode, want_r.drive,
                     want_r.drive_pulse, want_r.last);
            $display("             got      servo %0d mode %0d drive %0b pulse %0d last %0b",
                     result.servo_index, result.mode, result.drive,
                     result.drive_pulse, result.last);
          end
        end
      end
    end
  end

  initial begin
    #(4 * 400000);
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    cfg_now = make_cfg(TIMEOUT_RST, 4'd0, 1'b0, 12'd0, RX_MAP_RST);
    now_ms  = '0;
    for (int s = 0; s < NSERVO; s++) begin
      stamp[s]      = '0;
      servo_mode[s] = MODE_HOST;
    end
    for (int c = 0; c < NCHAN; c++) chan_pulse[c] = '0;

    // defaults after reset, field extremes, dropped indexes
    plan.push_back(row_check(OP_EVALUATE, 0, 0,
                             make_result(0, MODE_HOST, 1'b0, 12'd0, 1'b1)));
    plan.push_back(row_check(OP_HOST_SET, 7, 4095,
                             make_result(7, MODE_HOST, 1'b1, 12'd4095, 1'b1)));
    plan.push_back(row_check(OP_HOST_SET, 0, 0,
                             make_result(0, MODE_HOST, 1'b1, 12'd0, 1'b1)));
    plan.push_back(row_item(OP_HOST_SET, 8, 100));
    plan.push_back(row_item(OP_EVALUATE, 15, 4095));
    plan.push_back(row_item(OP_RX_UPDATE, 15, 4095));
    plan.push_back(row_item(OP_RX_UPDATE, 8, 1000));
    plan.push_back(row_item(OP_RX_UPDATE, 3, 4095));
    plan.push_back(row_item(OP_TICK, 15, 4095));
    // zero timeout: a stamp from an earlier millisecond is already stale
    plan.push_back(row_settings(make_cfg(16'd0, 4'd0, 1'b0, 12'd0, RX_MAP_RST)));
    plan.push_back(row_check(OP_EVALUATE, 3, 0,
                             make_result(3, MODE_FAILSAFE, 1'b1, 12'd0, 1'b1)));
    plan.push_back(row_check(OP_HOST_SET, 3, 2000,
                             make_result(3, MODE_HOST, 1'b1, 12'd2000, 1'b1)));
    // forced fallback from channel 1 above the threshold
    plan.push_back(row_settings(make_cfg(16'hFFFF, 4'd1, 1'b1, 12'd1000, RX_MAP_RST)));
    plan.push_back(row_item(OP_RX_UPDATE, 1, 1500));
    plan.push_back(row_item(OP_EVALUATE, 3, 0));
    // an invalid channel value still drives the servos in rx mode
    plan.push_back(row_check(OP_RX_UPDATE, 3, 0,
                             make_result(3, MODE_RX, 1'b1, 12'd0, 1'b1)));
    plan.push_back(row_item(OP_EVALUATE, 3, 0));
    plan.push_back(row_item(OP_RX_UPDATE, 1, 500));
    plan.push_back(row_item(OP_HOST_SET, 3, 1234));
    // two servos sharing one channel, forced from below the threshold
    plan.push_back(row_settings(make_cfg(16'hFFFF, 4'd0, 1'b0, 12'd3000, 32'h5555_5555)));
    plan.push_back(row_item(OP_RX_UPDATE, 0, 100));
    plan.push_back(row_item(OP_RX_UPDATE, 5, 2500));
    plan.push_back(row_item(OP_EVALUATE, 1, 0));
    plan.push_back(row_item(OP_EVALUATE, 6, 0));
    plan.push_back(row_item(OP_RX_UPDATE, 5, 4095));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[k]) begin
      if (plan[k].set_row) apply_settings(plan[k].cfg);
      else send_item(plan[k].it, plan[k].typed, plan[k].want);
    end

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      apply_settings(phase_settings(ph));
      calm = (ph == PHASE_COUNT - 1);
      // hold the result side while items keep coming, so the block backs up
      if (ph == 1) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 3 && i == PHASE_ITEMS / 2) begin
          push <= 1'b0;
          do @(posedge clk); while (due_results.size() != 0);
        end
        send_item(random_item(), 1'b0, '0);
        if (!calm && ph != 1 && $urandom_range(0, 3) == 0) pause($urandom_range(1, 11));
      end
    end

    push <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    bad_results += due_results.size();

    $display("covered %0d transactions (%0d without result), %0d results: %0d host, %0d rx, %0d failsafe",
             items_in, silent_items, results_seen, mode_count[MODE_HOST], mode_count[MODE_RX],
             mode_count[MODE_FAILSAFE]);
    $display("%0d register settings applied, input held off by full for %0d cycles",
             settings_used, full_stalls);
    if (bad_results == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
